[rtl/ffsa_pkg.sv]
`default_nettype none
package ffsa_pkg;
    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_MARK     = 2'd1,
        OP_ALLOCATE = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_DISK_FULL = 2'd2;

    localparam int unsigned SectorsPerTrack = 10;
    localparam logic [9:0]  TotalReset      = 10'd800;

    // Control word for the chain of map cells.
    typedef struct packed {
        logic clear;
        logic mark;
        logic probe;
    } t_cell_ctl;
endpackage
`default_nettype wire

[rtl/first_fit_sector_allocator.sv]
// Sequence: clear, unused codes and allocates that need no search (too large or
// zero length) pass from acceptance through S_DIV and S_OUT to o_valid; mark and
// searching allocates first rotate the whole map once in S_WALK.
// Flow: one transaction at a time, accepted only after the previous result has left.
// Reset: synchronous active low; sectors 0 and 1 are set, total is 800.
`default_nettype none
module first_fit_sector_allocator #(
    parameter int unsigned MAP_SECTORS = 800
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [9:0]  i_cfg_data,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire [1:0]  i_operation,
    input  wire [9:0]  i_start_sector,
    input  wire [17:0] i_length_bytes,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [1:0] o_status,
    output logic [9:0] o_found_sector,
    output logic [6:0] o_found_track,
    output logic [3:0] o_found_sector_in_track
);
    localparam int unsigned IW = $clog2(MAP_SECTORS + 1);
    localparam logic [IW-1:0] LastIdx = IW'(MAP_SECTORS - 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DIV, S_OUT} t_state;

    t_state             r_state;
    logic [9:0]         r_total;
    logic [1:0]         r_op;
    logic [10:0]        r_lo;       // mark extent start
    logic [18:0]        r_hi;       // mark extent end, exclusive
    logic [10:0]        r_need;
    logic [IW-1:0]      r_pos;      // sector number at the head cell
    logic [10:0]        r_run;
    logic               r_found;
    logic [9:0]         r_eff;
    logic [9:0]         r_sec;
    logic [6:0]         r_trk;
    logic [3:0]         r_rem;
    logic [1:0]         r_st;
    logic               r_clr;

    logic [MAP_SECTORS-1:0] w_map;
    logic [MAP_SECTORS-1:0] w_prev;
    ffsa_pkg::t_cell_ctl    w_ctl;
    logic [10:0]            w_need;
    logic [9:0]             w_eff;
    logic                   w_acc;
    logic                   w_head_set;
    logic                   w_free;
    logic                   w_scan;
    logic                   w_hit;

    assign w_acc  = i_valid && !o_stall;
    // A pending result holds off the next transaction.
    assign o_stall = (r_state != S_IDLE) || o_valid;
    assign w_need = 11'(i_length_bytes[17:8]) + 11'(|i_length_bytes[7:0]);
    always_comb begin
        w_eff = r_total;
        if (r_total < 10'd2) begin
            w_eff = 10'd2;
        end else if (32'(r_total) > MAP_SECTORS) begin
            w_eff = 10'(MAP_SECTORS);
        end
    end

    assign w_ctl.clear = r_clr;
    assign w_ctl.probe = (r_state == S_WALK);
    assign w_ctl.mark  = w_ctl.probe && (r_op == ffsa_pkg::OP_MARK) &&
                         (19'(r_pos) >= 19'(r_lo)) && (19'(r_pos) < r_hi);
    // Head cell holds sector r_pos; it is set as it passes when marked.
    assign w_head_set = w_ctl.mark;
    assign w_free = !w_map[0];

    // Search window is sectors 1 .. eff-1; a hit may land on the last walk cycle.
    assign w_scan = w_ctl.probe && (r_op == ffsa_pkg::OP_ALLOCATE) && !r_found &&
                    (r_pos != '0) && (32'(r_pos) < 32'(r_eff));
    assign w_hit  = w_scan && w_free && (r_run + 11'd1 >= r_need);

    // The head bit wraps around to the tail of the chain.
    assign w_prev = {w_map[0] | w_head_set, w_map[MAP_SECTORS-1:1]};

    // Chain of cells: cell k holds sector (r_pos + k) mod MAP_SECTORS.
    for (genvar k = 0; k < MAP_SECTORS; k++) begin : g_cell
        ffsa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_reset_val((k == 0 || k == 1) ? 1'b1 : 1'b0),
            .i_shift    (w_ctl.probe),
            .i_set      (1'b0),
            .i_clr      (w_ctl.clear),
            .i_prev     (w_prev[k]),
            .o_bit      (w_map[k])
        );
    end

    // Sequencer: one clocked block for state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= ffsa_pkg::TotalReset;
            r_clr   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_clr <= 1'b0;
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_valid && !i_stall) begin
                        o_valid <= 1'b0;
                    end
                    if (w_acc) begin
                        r_op    <= i_operation;
                        r_lo    <= 11'(i_start_sector);
                        r_hi    <= 19'(i_start_sector) + 19'(w_need);
                        r_need  <= w_need;
                        r_eff   <= w_eff;
                        r_pos   <= '0;
                        r_run   <= '0;
                        r_found <= 1'b0;
                        r_sec   <= '0;
                        r_st    <= ffsa_pkg::ST_OK;
                        r_state <= S_DIV;
                        if (i_operation == ffsa_pkg::OP_CLEAR) begin
                            r_clr <= 1'b1;
                        end else if (i_operation == ffsa_pkg::OP_MARK) begin
                            r_state <= S_WALK;
                        end else if (i_operation == ffsa_pkg::OP_ALLOCATE) begin
                            if (w_need > 11'(w_eff - 10'd2)) begin
                                r_st <= ffsa_pkg::ST_TOO_LARGE;
                            end else if (w_need == '0) begin
                                r_sec <= 10'd1;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end
                    end
                end
                S_WALK: begin
                    // Run counting over sectors 1 .. eff-1 as they pass the head.
                    if (w_scan) begin
                        if (!w_free) begin
                            r_run <= '0;
                        end else begin
                            r_run <= r_run + 11'd1;
                            if (w_hit) begin
                                r_found <= 1'b1;
                                r_sec   <= 10'(11'(r_pos) + 11'd1 - r_need);
                            end
                        end
                    end
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == LastIdx) begin
                        if (r_op == ffsa_pkg::OP_ALLOCATE && !r_found && !w_hit) begin
                            r_st <= ffsa_pkg::ST_DISK_FULL;
                        end
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Track number from the sector; the sector in track follows in S_OUT.
                    r_trk   <= 7'((18'(r_sec) * 18'd205) >> 11);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_rem   <= 4'(r_sec - 10'(r_trk) * 10'(ffsa_pkg::SectorsPerTrack));
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status               = r_st;
    assign o_found_sector         = r_sec;
    assign o_found_track          = r_trk;
    assign o_found_sector_in_track = r_rem;

    // A finished search never exceeds the map.
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_found_sector) < MAP_SECTORS))
        else $error("found sector beyond map");
    // Non-ok results carry a zero sector.
    a_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ffsa_pkg::ST_OK) |-> (o_found_sector == '0))
        else $error("error result with nonzero sector");
    // No new transaction starts while the map walk is running.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> o_stall)
        else $error("accepting during walk");
endmodule
`default_nettype wire

[rtl/ffsa_cell.sv]
`default_nettype none
// One occupancy bit of the sector map. The map is a circular shift line:
// each cell passes its bit to the next cell every rotate cycle.
module ffsa_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_reset_val,
    input  wire              i_shift,
    input  wire              i_set,
    input  wire              i_clr,
    input  wire              i_prev,
    output logic             o_bit
);
    logic r_bit;
    logic n_bit;

    // Next value: clear wins over a set, and a set wins over the shifted bit.
    always_comb begin
        n_bit = r_bit;
        if (i_shift) begin
            n_bit = i_prev;
        end
        if (i_set) begin
            n_bit = 1'b1;
        end
        if (i_clr) begin
            n_bit = i_reset_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= i_reset_val;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;
endmodule
`default_nettype wire
